>>> rtl/xrg_pkg.sv
`timescale 1ns / 1ps
package xrg_pkg;

	localparam int WORD_W = 64;
	localparam int HALF_W = WORD_W / 2;
	localparam int CMD_W  = 3;
	localparam int LEAP_STEPS = 4 * WORD_W;
	localparam int LEAP_CNT_W = $clog2(LEAP_STEPS);

	// command codes
	localparam logic [CMD_W-1:0] CMD_NEXT      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FRAC      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_JUMP      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LONG_JUMP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEED      = 3'd4;

	localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
	localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
	localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;

	// jump polynomials, word 0 in the low bits
	localparam logic [LEAP_STEPS-1:0] SHORT_POLY = {
		64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
		64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba};
	localparam logic [LEAP_STEPS-1:0] LONG_POLY = {
		64'h39109bb02acbe635, 64'h77710069854ee241,
		64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf};

	typedef logic [3:0][WORD_W-1:0] gen_state_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] p;
	} mul_rsp_t;

	// one xoshiro256 state step
	function automatic gen_state_t xrg_advance(input gen_state_t s);
		gen_state_t n;
		logic [WORD_W-1:0] t;
		t    = s[1] << 17;
		n[2] = s[2] ^ s[0];
		n[3] = s[3] ^ s[1];
		n[1] = s[1] ^ n[2];
		n[0] = s[0] ^ n[3];
		n[2] = n[2] ^ t;
		n[3] = {n[3][WORD_W-46:0], n[3][WORD_W-1:WORD_W-45]};
		return n;
	endfunction

endpackage

>>> rtl/xrg_if.sv
`timescale 1ns / 1ps
interface xrg_req_if import xrg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [WORD_W-1:0] seed_value;

	modport source (output valid, output cmd, output seed_value, input ready);
	modport sink (input valid, input cmd, input seed_value, output ready);
endinterface

interface xrg_rsp_if import xrg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] value;
	logic              has_value;

	modport source (output valid, output value, output has_value, input ready);
	modport sink (input valid, input value, input has_value, output ready);
endinterface

>>> rtl/xrg_mul64.sv
`timescale 1ns / 1ps
module xrg_mul64 import xrg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	typedef enum logic [2:0] {M_IDLE, M_P0, M_P1, M_P2, M_P3} mstate_t;

	mstate_t           state_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] prod_q;
	logic [WORD_W-1:0] acc_q;
	logic              done_q;
	logic [HALF_W-1:0] op_a;
	logic [HALF_W-1:0] op_b;
	logic [WORD_W-1:0] mul_out;

	// one 32x32 multiplier, fed a different half pair in each of phases P0, P1 and P2
	always_comb begin
		unique case (state_q)
			M_P1: begin
				op_a = a_q[HALF_W-1:0];
				op_b = b_q[WORD_W-1:HALF_W];
			end
			M_P2: begin
				op_a = a_q[WORD_W-1:HALF_W];
				op_b = b_q[HALF_W-1:0];
			end
			default: begin
				op_a = a_q[HALF_W-1:0];
				op_b = b_q[HALF_W-1:0];
			end
		endcase
	end

	assign mul_out = WORD_W'(op_a) * WORD_W'(op_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						a_q     <= req.a;
						b_q     <= req.b;
						state_q <= M_P0;
					end
				end
				M_P0: begin
					prod_q  <= mul_out;
					state_q <= M_P1;
				end
				M_P1: begin
					acc_q   <= prod_q;
					prod_q  <= mul_out;
					state_q <= M_P2;
				end
				M_P2: begin
					acc_q   <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
					prod_q  <= mul_out;
					state_q <= M_P3;
				end
				M_P3: begin
					acc_q   <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q;

endmodule

>>> rtl/xoshiro256_random_generator_unit.sv
`timescale 1ns / 1ps
// channel | modport | payload               | transfer when
// req     | sink    | cmd, seed_value       | req.valid && req.ready
// rsp     | source  | value, has_value      | rsp.valid && rsp.ready
//
// next: S_SUM, then S_ROT, then S_OUT, which waits for a free output slot; no new command until S_IDLE
// fraction: S_SUM, then S_OUT, which waits for a free output slot; no new command until S_IDLE
// jump and long jump: 256 state steps in S_LEAP, one per cycle, then S_OUT
// seed: three splitmix64 words through the shared 32x32 multiplier
// after reset the block seeds itself with zero (req.ready low)
// a waiting result does not block a new transfer; the next result waits for the slot
module xoshiro256_random_generator_unit import xrg_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	xrg_req_if.sink  req,
	xrg_rsp_if.source rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_SUM, S_ROT, S_LEAP,
		S_SEED_LOAD, S_SEED_ADD, S_MUL_A, S_MUL_B, S_OUT
	} fsm_t;

	localparam logic [LEAP_CNT_W-1:0] LEAP_LAST = LEAP_CNT_W'(LEAP_STEPS - 1);

	fsm_t              fsm_q;
	logic              init_q;       // self-seed after reset, result dropped
	gen_state_t        gen_q;        // the generator state
	gen_state_t        acc_q;        // jump accumulator
	logic [WORD_W-1:0] seed_q;       // splitmix64 counter
	logic [WORD_W-1:0] sum_q;        // word0 + word3 of the pre-step state
	logic [WORD_W-1:0] s0_old_q;     // word0 of the pre-step state
	logic [1:0]        word_q;       // word being seeded
	logic [LEAP_CNT_W-1:0] cnt_q;    // jump step
	logic              long_q;       // long jump polynomial
	logic              frac_q;       // fraction instead of plus-plus
	logic [WORD_W-1:0] res_value_q;
	logic              res_has_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] value_q;
	logic              has_q;

	// shared 64-bit adder
	logic [WORD_W-1:0] add_a;
	logic [WORD_W-1:0] add_b;
	logic [WORD_W-1:0] add_sum;

	mul_req_t          mul_req;
	mul_rsp_t          mul_rsp;
	logic [WORD_W-1:0] mix_in_a;     // z ^ (z >> 30) of the new counter
	logic [WORD_W-1:0] mix_in_b;     // second splitmix fold
	logic [WORD_W-1:0] mix_out;      // final splitmix fold

	logic              poly_bit;
	gen_state_t        leap_acc;
	logic              slot_free;
	logic              out_load;     // result moves into the output slot this cycle

	always_comb begin
		unique case (fsm_q)
			S_SUM: begin
				add_a = gen_q[0];
				add_b = gen_q[3];
			end
			S_ROT: begin
				// rotate left by 23
				add_a = {sum_q[WORD_W-24:0], sum_q[WORD_W-1:WORD_W-23]};
				add_b = s0_old_q;
			end
			default: begin
				add_a = seed_q;
				add_b = GOLDEN_INC;
			end
		endcase
	end

	assign add_sum = add_a + add_b;

	assign mix_in_a = add_sum ^ (add_sum >> 30);
	assign mix_in_b = mul_rsp.p ^ (mul_rsp.p >> 27);
	assign mix_out  = mul_rsp.p ^ (mul_rsp.p >> 31);

	// multiplier start: new counter value, then the second multiply right after the first
	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a     = mix_in_a;
		mul_req.b     = MIX_MUL_A;
		if (fsm_q == S_SEED_ADD) begin
			mul_req.start = 1'b1;
		end else if (fsm_q == S_MUL_A && mul_rsp.done) begin
			mul_req.start = 1'b1;
			mul_req.a     = mix_in_b;
			mul_req.b     = MIX_MUL_B;
		end
	end

	xrg_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// fold the current state into the accumulator where the polynomial bit is set
	assign poly_bit = long_q ? LONG_POLY[cnt_q] : SHORT_POLY[cnt_q];
	assign leap_acc = poly_bit ? (acc_q ^ gen_q) : acc_q;

	assign slot_free = !out_valid_q || rsp.ready;
	assign out_load  = (fsm_q == S_OUT) && !init_q && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= S_SEED_LOAD;
			init_q      <= 1'b1;
			seed_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (fsm_q)
				S_IDLE: begin
					if (req.valid) begin
						res_value_q <= '0;
						res_has_q   <= 1'b0;
						unique case (req.cmd)
							CMD_NEXT, CMD_FRAC: begin
								frac_q <= (req.cmd == CMD_FRAC);
								fsm_q  <= S_SUM;
							end
							CMD_JUMP, CMD_LONG_JUMP: begin
								long_q <= (req.cmd == CMD_LONG_JUMP);
								acc_q  <= '0;
								cnt_q  <= '0;
								fsm_q  <= S_LEAP;
							end
							CMD_SEED: begin
								seed_q <= req.seed_value;
								fsm_q  <= S_SEED_LOAD;
							end
							default: fsm_q <= S_OUT;   // unused codes leave the state alone
						endcase
					end
				end
				S_SUM: begin
					sum_q    <= add_sum;
					s0_old_q <= gen_q[0];
					gen_q    <= xrg_advance(gen_q);
					if (frac_q) begin
						res_value_q <= add_sum >> 11;
						res_has_q   <= 1'b1;
						fsm_q       <= S_OUT;
					end else begin
						fsm_q <= S_ROT;
					end
				end
				S_ROT: begin
					res_value_q <= add_sum;
					res_has_q   <= 1'b1;
					fsm_q       <= S_OUT;
				end
				S_LEAP: begin
					acc_q <= leap_acc;
					cnt_q <= cnt_q + LEAP_CNT_W'(1);
					if (cnt_q == LEAP_LAST) begin
						gen_q <= leap_acc;
						fsm_q <= S_OUT;
					end else begin
						gen_q <= xrg_advance(gen_q);
					end
				end
				S_SEED_LOAD: begin
					gen_q[0] <= seed_q;
					word_q   <= 2'd1;
					fsm_q    <= S_SEED_ADD;
				end
				S_SEED_ADD: begin
					seed_q <= add_sum;
					fsm_q  <= S_MUL_A;
				end
				S_MUL_A: begin
					if (mul_rsp.done) begin
						fsm_q <= S_MUL_B;
					end
				end
				S_MUL_B: begin
					if (mul_rsp.done) begin
						gen_q[word_q] <= mix_out;
						if (word_q == 2'd3) begin
							res_value_q <= '0;
							res_has_q   <= 1'b0;
							fsm_q       <= S_OUT;
						end else begin
							word_q <= word_q + 2'd1;
							fsm_q  <= S_SEED_ADD;
						end
					end
				end
				S_OUT: begin
					if (init_q) begin
						init_q <= 1'b0;
						fsm_q  <= S_IDLE;
					end else if (slot_free) begin
						out_valid_q <= 1'b1;
						value_q     <= res_value_q;
						has_q       <= res_has_q;
						fsm_q       <= S_IDLE;
					end
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready     = (fsm_q == S_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.value     = value_q;
	assign rsp.has_value = has_q;

endmodule

>>> rtl/xrg_checker.sv
`timescale 1ns / 1ps
module xrg_checker import xrg_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	xrg_req_if.sink   req,
	xrg_rsp_if.source rsp
);

	// one command at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("ready stayed high after a command transfer");

	// jumps hold ready low after the transfer
	a_jump_long: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && (req.cmd == CMD_JUMP || req.cmd == CMD_LONG_JUMP)
		|-> ##8 !req.ready)
		else $error("jump finished too early");

	// a new result only comes out of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("result appeared without a command in progress");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.value)
		&& $stable(rsp.has_value))
		else $error("stalled result changed");

	// jump, seed and unused codes give zero
	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.has_value |-> rsp.value == '0)
		else $error("non-random result is not zero");

endmodule

bind xoshiro256_random_generator_unit xrg_checker u_xrg_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

>>> dv/tb_xoshiro256_random_generator_unit.sv
`timescale 1ns / 1ps
module tb_xoshiro256_random_generator_unit import xrg_pkg::*; ();

	// codes 5 to 7 are not decoded and must leave the state untouched
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [WORD_W-1:0] value;
		logic              has_value;
	} word_expect_t;

	logic clk;
	logic arst_n;

	xrg_req_if req_ch ();
	xrg_rsp_if rsp_ch ();

	xoshiro256_random_generator_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// model of the generator state, expectations in issue order
	gen_state_t   gen_words;
	word_expect_t pending_words[$];
	int           mismatch_count;
	int           checked_count;
	int           cmd_seen[8];
	bit           quiet;

	// one xoshiro256 state step
	function automatic gen_state_t words_step(input gen_state_t s);
		gen_state_t n;
		logic [WORD_W-1:0] shifted;
		n = s;
		shifted = n[1] << 17;
		n[2] = n[2] ^ n[0];
		n[3] = n[3] ^ n[1];
		n[1] = n[1] ^ n[2];
		n[0] = n[0] ^ n[3];
		n[2] = n[2] ^ shifted;
		n[3] = {n[3][18:0], n[3][63:19]};
		return n;
	endfunction

	// splitmix64 expansion: word 0 is the seed itself
	function automatic gen_state_t words_from_seed(input logic [WORD_W-1:0] seed);
		gen_state_t n;
		logic [WORD_W-1:0] acc;
		logic [WORD_W-1:0] z;
		acc = seed;
		n[0] = seed;
		for (int w = 1; w < 4; w++) begin
			acc = acc + GOLDEN_INC;
			z = acc;
			z = (z ^ (z >> 30)) * MIX_MUL_A;
			z = (z ^ (z >> 27)) * MIX_MUL_B;
			n[w] = z ^ (z >> 31);
		end
		return n;
	endfunction

	// polynomial jump: fold the state into an accumulator at every set bit
	function automatic gen_state_t words_leap(input gen_state_t s,
			input logic [LEAP_STEPS-1:0] poly);
		gen_state_t acc;
		gen_state_t cur;
		acc = '0;
		cur = s;
		for (int i = 0; i < LEAP_STEPS; i++) begin
			if (poly[i]) begin
				acc = acc ^ cur;
			end
			cur = words_step(cur);
		end
		return acc;
	endfunction

	// work out the result of one command and move the model state along
	task automatic predict_word(input logic [CMD_W-1:0] c, input logic [WORD_W-1:0] seed);
		word_expect_t e;
		logic [WORD_W-1:0] sum;
		e.cmd = c;
		e.value = '0;
		e.has_value = 1'b0;
		sum = gen_words[0] + gen_words[3];
		case (c)
			CMD_NEXT: begin
				e.value = {sum[40:0], sum[63:41]} + gen_words[0];
				e.has_value = 1'b1;
				gen_words = words_step(gen_words);
			end
			CMD_FRAC: begin
				e.value = sum >> 11;
				e.has_value = 1'b1;
				gen_words = words_step(gen_words);
			end
			CMD_JUMP: begin
				gen_words = words_leap(gen_words, SHORT_POLY);
			end
			CMD_LONG_JUMP: begin
				gen_words = words_leap(gen_words, LONG_POLY);
			end
			CMD_SEED: begin
				gen_words = words_from_seed(seed);
			end
			default: begin
			end
		endcase
		pending_words.push_back(e);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// responses are checked first, then new commands are predicted, in one process
	always @(posedge clk) begin
		word_expect_t e;
		if (rsp_ch.valid && rsp_ch.ready) begin
			checked_count++;
			if (pending_words.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with nothing expected, value %h has_value %b",
					$time, rsp_ch.value, rsp_ch.has_value);
			end else begin
				e = pending_words.pop_front();
				if (rsp_ch.value !== e.value) begin
					mismatch_count++;
					$display("%0t: cmd %0d value expected %h actual %h",
						$time, e.cmd, e.value, rsp_ch.value);
				end
				if (rsp_ch.has_value !== e.has_value) begin
					mismatch_count++;
					$display("%0t: cmd %0d has_value expected %b actual %b",
						$time, e.cmd, e.has_value, rsp_ch.has_value);
				end
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			cmd_seen[req_ch.cmd]++;
			predict_word(req_ch.cmd, req_ch.seed_value);
		end
	end

	// result side: ready drops in random bursts, none once quiet is set
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// watchdog
	initial begin
		#12ms;
		$display("tb_xoshiro256_random_generator_unit: errors");
		$finish;
	end

	// one command transfer, with an optional gap in front; valid stays high after
	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [WORD_W-1:0] seed);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= c;
		req_ch.seed_value <= seed;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] pick_seed();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, WORD_W - 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// reset seeding must match a seed of zero
	task automatic test_reset_state();
		send_cmd(CMD_NEXT, '0);
		send_cmd(CMD_FRAC, '1);
		send_cmd(CMD_NEXT, '0);
	endtask

	task automatic test_seed_extremes();
		send_cmd(CMD_SEED, '0);
		send_cmd(CMD_NEXT, '1);
		send_cmd(CMD_SEED, '1);
		send_cmd(CMD_FRAC, '0);
		send_cmd(CMD_NEXT, '0);
		send_cmd(CMD_SEED, 64'h1);
		send_cmd(CMD_NEXT, '0);
		send_cmd(CMD_SEED, 64'h8000_0000_0000_0000);
		send_cmd(CMD_FRAC, '0);
	endtask

	task automatic test_leaps();
		send_cmd(CMD_JUMP, '1);
		send_cmd(CMD_NEXT, '0);
		send_cmd(CMD_LONG_JUMP, '0);
		send_cmd(CMD_FRAC, '0);
		send_cmd(CMD_JUMP, '0);
		send_cmd(CMD_LONG_JUMP, '1);
		send_cmd(CMD_NEXT, '0);
	endtask

	// undecoded codes give an empty result and keep the state
	task automatic test_spare_codes();
		for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
			send_cmd(c[CMD_W-1:0], '1);
		end
		send_cmd(CMD_NEXT, '0);
	endtask

	// mostly seeded runs of outputs, with rare jumps and spare codes
	task automatic test_random_mix(input int n_items);
		int sent;
		int pick;
		int run_len;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_cmd(CMD_SEED, pick_seed());
				sent++;
				run_len = $urandom_range(3, 20);
				for (int i = 0; i < run_len; i++) begin
					send_cmd($urandom_range(0, 1) ? CMD_NEXT : CMD_FRAC, {$urandom, $urandom});
					sent++;
				end
			end else if (pick < 50) begin
				send_cmd(CMD_NEXT, {$urandom, $urandom});
				sent++;
			end else if (pick < 88) begin
				send_cmd(CMD_FRAC, {$urandom, $urandom});
				sent++;
			end else if (pick < 91) begin
				send_cmd(CMD_JUMP, {$urandom, $urandom});
				sent++;
			end else if (pick < 93) begin
				send_cmd(CMD_LONG_JUMP, {$urandom, $urandom});
				sent++;
			end else if (pick < 96) begin
				send_cmd(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
					{$urandom, $urandom});
				sent++;
			end else begin
				send_cmd(CMD_SEED, pick_seed());
				sent++;
			end
		end
	endtask

	// no idling on either side: commands at full rate
	task automatic test_back_to_back(input int n_items);
		quiet = 1'b1;
		send_cmd(CMD_SEED, {$urandom, $urandom});
		for (int i = 1; i < n_items; i++) begin
			if (i % 40 == 0) begin
				send_cmd(CMD_JUMP, '0);
			end else begin
				send_cmd($urandom_range(0, 1) ? CMD_NEXT : CMD_FRAC, {$urandom, $urandom});
			end
		end
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		quiet = 1'b0;
		mismatch_count = 0;
		checked_count = 0;
		foreach (cmd_seen[i]) cmd_seen[i] = 0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_NEXT;
		req_ch.seed_value = '0;
		// state after reset equals a zero seed
		gen_words = words_from_seed('0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_seed_extremes();
		test_leaps();
		test_spare_codes();
		test_random_mix(1180);
		test_back_to_back(100);

		req_ch.valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		// catch any stray result after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("ran %0d next, %0d fraction, %0d jump, %0d long jump, %0d seed, %0d spare",
			cmd_seen[CMD_NEXT], cmd_seen[CMD_FRAC], cmd_seen[CMD_JUMP],
			cmd_seen[CMD_LONG_JUMP], cmd_seen[CMD_SEED],
			cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
		$display("checked %0d results, %0d mismatches, %0d still outstanding",
			checked_count, mismatch_count, pending_words.size());
		if (mismatch_count == 0 && pending_words.size() == 0) begin
			$display("tb_xoshiro256_random_generator_unit: clean");
		end else begin
			$display("tb_xoshiro256_random_generator_unit: errors");
		end
		$finish;
	end

endmodule
